>>> rtl/kvmd_pkg.sv
// ----------------------------------------------------------------------------
// kvmd_pkg
// Shared widths, key codes, vote status type and the multi-tap helper
// for the keypad vote multi-tap decoder.
// ----------------------------------------------------------------------------
package kvmd_pkg;

	localparam int CNT_W  = 10;
	localparam int KEY_W  = 7;
	localparam int ROW_W  = 4;
	localparam int COL_W  = 3;
	localparam int ROWS   = 4;
	localparam int ROWI_W = $clog2(ROWS);

	localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(400);

	// column flag bit positions
	localparam int COL_MID   = 0;
	localparam int COL_LEFT  = 1;
	localparam int COL_RIGHT = 2;

	// row indexes after the vote
	localparam logic [ROWI_W-1:0] ROW_1 = ROWI_W'(0);
	localparam logic [ROWI_W-1:0] ROW_2 = ROWI_W'(1);
	localparam logic [ROWI_W-1:0] ROW_3 = ROWI_W'(2);
	localparam logic [ROWI_W-1:0] ROW_4 = ROWI_W'(3);

	// key codes
	localparam logic [KEY_W-1:0] KEY_CLEAR = KEY_W'(0);
	localparam logic [KEY_W-1:0] KEY_SPACE = KEY_W'(8'h20);
	localparam logic [KEY_W-1:0] KEY_STAR  = KEY_W'(42);
	localparam logic [KEY_W-1:0] KEY_D0    = KEY_W'(48);
	localparam logic [KEY_W-1:0] KEY_D1    = KEY_W'(49);
	localparam logic [KEY_W-1:0] KEY_D2    = KEY_W'(50);
	localparam logic [KEY_W-1:0] KEY_D3    = KEY_W'(51);
	localparam logic [KEY_W-1:0] KEY_D4    = KEY_W'(52);
	localparam logic [KEY_W-1:0] KEY_D5    = KEY_W'(53);
	localparam logic [KEY_W-1:0] KEY_D6    = KEY_W'(54);
	localparam logic [KEY_W-1:0] KEY_D7    = KEY_W'(55);
	localparam logic [KEY_W-1:0] KEY_D8    = KEY_W'(56);
	localparam logic [KEY_W-1:0] KEY_D9    = KEY_W'(57);
	localparam logic [KEY_W-1:0] KEY_A     = KEY_W'(65);
	localparam logic [KEY_W-1:0] KEY_D     = KEY_W'(68);
	localparam logic [KEY_W-1:0] KEY_G     = KEY_W'(71);
	localparam logic [KEY_W-1:0] KEY_J     = KEY_W'(74);
	localparam logic [KEY_W-1:0] KEY_M     = KEY_W'(77);
	localparam logic [KEY_W-1:0] KEY_P     = KEY_W'(80);
	localparam logic [KEY_W-1:0] KEY_Q     = KEY_W'(81);
	localparam logic [KEY_W-1:0] KEY_R     = KEY_W'(82);
	localparam logic [KEY_W-1:0] KEY_S     = KEY_W'(83);
	localparam logic [KEY_W-1:0] KEY_T     = KEY_W'(84);
	localparam logic [KEY_W-1:0] KEY_W_LET = KEY_W'(87);
	localparam logic [KEY_W-1:0] KEY_Z     = KEY_W'(90);

	typedef struct packed {
		logic              decide;
		logic [ROWI_W-1:0] row;
	} vote_t;

	// next letter of a three-letter group, wrapping to the first; first letter when not in the group
	function automatic logic [KEY_W-1:0] cycle3(input logic [KEY_W-1:0] key,
			input logic [KEY_W-1:0] base);
		logic [KEY_W-1:0] res;
		if (key == base) begin
			res = base + KEY_W'(1);
		end else if (key == base + KEY_W'(1)) begin
			res = base + KEY_W'(2);
		end else begin
			res = base;
		end
		return res;
	endfunction

endpackage

>>> rtl/kvmd_vote.sv
// ----------------------------------------------------------------------------
// kvmd_vote
// Row vote counters and sample counter; flags a decision and picks the
// row with the most votes, lowest index on a tie.
// ----------------------------------------------------------------------------
module kvmd_vote (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic [kvmd_pkg::ROW_W-1:0]    row_lines,
	input  logic [kvmd_pkg::CNT_W-1:0]    sample_limit,
	output kvmd_pkg::vote_t               vote
);

	logic [kvmd_pkg::CNT_W-1:0]  votes_q [kvmd_pkg::ROWS];
	logic [kvmd_pkg::CNT_W-1:0]  votes_nxt [kvmd_pkg::ROWS];
	logic [kvmd_pkg::CNT_W-1:0]  count_q;
	logic [kvmd_pkg::CNT_W-1:0]  count_nxt;
	logic [kvmd_pkg::ROWS-1:0]   inc;
	logic [kvmd_pkg::ROW_W-1:0]  src;
	logic [kvmd_pkg::ROWI_W-1:0] best;

	always_comb begin
		src = ~row_lines;
		// nibble bits 0,3,2,1 feed rows 1..4
		inc[0] = src[0];
		inc[1] = src[3];
		inc[2] = src[2];
		inc[3] = src[1];
		for (int i = 0; i < kvmd_pkg::ROWS; i++) begin
			votes_nxt[i] = votes_q[i] + kvmd_pkg::CNT_W'(inc[i]);
		end
		count_nxt = count_q + kvmd_pkg::CNT_W'(1);
		best = kvmd_pkg::ROW_1;
		for (int i = 1; i < kvmd_pkg::ROWS; i++) begin
			if (votes_nxt[i] > votes_nxt[best]) begin
				best = kvmd_pkg::ROWI_W'(i);
			end
		end
		vote.decide = (count_nxt > sample_limit);
		vote.row    = best;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < kvmd_pkg::ROWS; i++) begin
				votes_q[i] <= '0;
			end
		end else if (advance) begin
			if (vote.decide) begin
				count_q <= '0;
				for (int i = 0; i < kvmd_pkg::ROWS; i++) begin
					votes_q[i] <= '0;
				end
			end else begin
				count_q <= count_nxt;
				for (int i = 0; i < kvmd_pkg::ROWS; i++) begin
					votes_q[i] <= votes_nxt[i];
				end
			end
		end
	end

endmodule

>>> rtl/kvmd_keydec.sv
// ----------------------------------------------------------------------------
// kvmd_keydec
// Key decoder: digits in number mode, multi-tap letters in letter mode,
// star toggles the mode, right column checked last.
// ----------------------------------------------------------------------------
module kvmd_keydec (
	input  logic [kvmd_pkg::ROWI_W-1:0] row,
	input  logic [kvmd_pkg::COL_W-1:0]  cols,
	input  logic [kvmd_pkg::KEY_W-1:0]  last_key,
	input  logic                        mode,
	output logic [kvmd_pkg::KEY_W-1:0]  key,
	output logic                        mode_nxt
);

	logic [kvmd_pkg::KEY_W-1:0] key_a;

	always_comb begin
		key_a    = last_key;
		mode_nxt = mode;
		if (cols[kvmd_pkg::COL_MID]) begin
			unique case (row)
				kvmd_pkg::ROW_1: key_a = mode ? kvmd_pkg::cycle3(last_key, kvmd_pkg::KEY_A)
					: kvmd_pkg::KEY_D2;
				kvmd_pkg::ROW_2: key_a = mode ? kvmd_pkg::cycle3(last_key, kvmd_pkg::KEY_J)
					: kvmd_pkg::KEY_D5;
				kvmd_pkg::ROW_3: key_a = mode ? kvmd_pkg::cycle3(last_key, kvmd_pkg::KEY_T)
					: kvmd_pkg::KEY_D8;
				default: key_a = !mode ? kvmd_pkg::KEY_D0
					: ((last_key == kvmd_pkg::KEY_Q) ? kvmd_pkg::KEY_Z : kvmd_pkg::KEY_Q);
			endcase
		end else if (cols[kvmd_pkg::COL_LEFT]) begin
			unique case (row)
				kvmd_pkg::ROW_1: key_a = mode ? kvmd_pkg::KEY_SPACE : kvmd_pkg::KEY_D1;
				kvmd_pkg::ROW_2: key_a = mode ? kvmd_pkg::cycle3(last_key, kvmd_pkg::KEY_G)
					: kvmd_pkg::KEY_D4;
				kvmd_pkg::ROW_3: begin
					if (!mode) begin
						key_a = kvmd_pkg::KEY_D7;
					end else if (last_key == kvmd_pkg::KEY_P) begin
						key_a = kvmd_pkg::KEY_R;
					end else if (last_key == kvmd_pkg::KEY_R) begin
						key_a = kvmd_pkg::KEY_S;
					end else begin
						key_a = kvmd_pkg::KEY_P;
					end
				end
				default: begin
					// star
					mode_nxt = ~mode;
					key_a    = kvmd_pkg::KEY_STAR;
				end
			endcase
		end
		key = key_a;
		if (cols[kvmd_pkg::COL_RIGHT]) begin
			unique case (row)
				kvmd_pkg::ROW_1: key = mode ? kvmd_pkg::cycle3(key_a, kvmd_pkg::KEY_D)
					: kvmd_pkg::KEY_D3;
				kvmd_pkg::ROW_2: key = mode ? kvmd_pkg::cycle3(key_a, kvmd_pkg::KEY_M)
					: kvmd_pkg::KEY_D6;
				kvmd_pkg::ROW_3: key = mode ? kvmd_pkg::cycle3(key_a, kvmd_pkg::KEY_W_LET)
					: kvmd_pkg::KEY_D9;
				default: key = kvmd_pkg::KEY_CLEAR;
			endcase
		end
	end

endmodule

>>> rtl/keypad_vote_multitap_decoder_unit.sv
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle unless a held result stalls; the input register
// feeds the vote and decode logic, which updates its state and the result register
// at the same edge. Only a decision item gives a result, and at most one.
// Reset (arst_n low, asynchronous): votes, sample count, last key and mode cleared,
// sample_limit back to 400, both stages empty.
// ----------------------------------------------------------------------------
// keypad_vote_multitap_decoder_unit
// Top level: input register, row vote, key decode and result register.
// ----------------------------------------------------------------------------
module keypad_vote_multitap_decoder_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [kvmd_pkg::CNT_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [kvmd_pkg::ROW_W-1:0]  row_lines,
	input  logic [kvmd_pkg::COL_W-1:0]  column_flags,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [kvmd_pkg::KEY_W-1:0]  key_code,
	output logic                        letter_mode
);

	logic [kvmd_pkg::CNT_W-1:0] limit_q;
	logic                       valid_s1;
	logic [kvmd_pkg::ROW_W-1:0] row_s1;
	logic [kvmd_pkg::COL_W-1:0] col_s1;
	logic [kvmd_pkg::KEY_W-1:0] last_key_q;
	logic                       mode_q;
	logic                       out_valid_q;
	logic [kvmd_pkg::KEY_W-1:0] key_q;
	logic                       letter_q;
	logic                       advance;
	logic                       emit;
	kvmd_pkg::vote_t            vote;
	logic [kvmd_pkg::KEY_W-1:0] key_dec;
	logic                       mode_dec;

	assign cfg_ready   = 1'b1;
	assign advance     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready    = !valid_s1 || advance;
	assign emit        = vote.decide && (key_dec != kvmd_pkg::KEY_STAR);
	assign out_valid   = out_valid_q;
	assign key_code    = key_q;
	assign letter_mode = letter_q;

	kvmd_vote u_vote (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.row_lines    (row_s1),
		.sample_limit (limit_q),
		.vote         (vote)
	);

	kvmd_keydec u_keydec (
		.row      (vote.row),
		.cols     (col_s1),
		.last_key (last_key_q),
		.mode     (mode_q),
		.key      (key_dec),
		.mode_nxt (mode_dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= kvmd_pkg::LIMIT_RST;
			valid_s1    <= 1'b0;
			last_key_q  <= '0;
			mode_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance && vote.decide) begin
				last_key_q <= key_dec;
				mode_q     <= mode_dec;
			end
			if (advance && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			row_s1 <= row_lines;
			col_s1 <= column_flags;
		end
		if (advance && emit) begin
			key_q    <= key_dec;
			letter_q <= mode_dec;
		end
	end

endmodule

>>> rtl/kvmd_checker.sv
// ----------------------------------------------------------------------------
// kvmd_checker
// Port-level checks on the result channel of the keypad decoder unit.
// ----------------------------------------------------------------------------
module kvmd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [kvmd_pkg::KEY_W-1:0] key_code,
	input logic                       letter_mode
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(key_code) && $stable(letter_mode))
		else $error("result changed while stalled");

	// star is never delivered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> key_code != kvmd_pkg::KEY_STAR)
		else $error("star key delivered");

	// digit mode only shows digits or the clear key
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !letter_mode |-> key_code == kvmd_pkg::KEY_CLEAR ||
			(key_code >= kvmd_pkg::KEY_D0 && key_code <= kvmd_pkg::KEY_D9))
		else $error("non-digit key in digit mode");

	// no code above the last letter
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> key_code <= kvmd_pkg::KEY_Z)
		else $error("key code out of range");

endmodule

bind keypad_vote_multitap_decoder_unit kvmd_checker u_kvmd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.key_code    (key_code),
	.letter_mode (letter_mode)
);

>>> tb/tb_keypad_vote_multitap_decoder_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keypad_vote_multitap_decoder_unit
// Drives keypad interrupt items into the decoder: every key in digit mode and a set
// of letter-mode taps at a sample limit of zero first, then random key presses with repeated taps,
// noise and mode toggles under several sample limits. A scoreboard keeps its
// own vote counters, mode and last key, predicts each decoded key and checks
// the results in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_keypad_vote_multitap_decoder_unit;
	import kvmd_pkg::*;

	localparam logic [COL_W-1:0] C_NONE  = '0;
	localparam logic [COL_W-1:0] C_MID   = COL_W'(1) << COL_MID;
	localparam logic [COL_W-1:0] C_LEFT  = COL_W'(1) << COL_LEFT;
	localparam logic [COL_W-1:0] C_RIGHT = COL_W'(1) << COL_RIGHT;
	localparam int HOLD_CYCLES    = 60;
	localparam int SETTLE_CYCLES  = 4;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             letter;
	} key_result_t;

	class key_tracker;
		logic [CNT_W-1:0] limit;
		logic [CNT_W-1:0] votes[ROWS];
		logic [CNT_W-1:0] count;
		logic [KEY_W-1:0] last_key;
		logic             letters;
		key_result_t      pending[$];
		int               errors;

		function new();
			limit = LIMIT_RST;
			count = '0;
			last_key = KEY_CLEAR;
			letters = 1'b0;
			errors = 0;
			foreach (votes[i]) votes[i] = '0;
		endfunction

		function void set_limit(logic [CNT_W-1:0] value);
			limit = value;
		endfunction

		function logic [KEY_W-1:0] tap_next(logic [KEY_W-1:0] cur, logic [KEY_W-1:0] first);
			if (cur == first) return first + KEY_W'(1);
			if (cur == first + KEY_W'(1)) return first + KEY_W'(2);
			return first;
		endfunction

		function void note_event(logic [ROW_W-1:0] lines, logic [COL_W-1:0] cols);
			logic [ROW_W-1:0]  act;
			logic [ROWI_W-1:0] row;
			logic [KEY_W-1:0]  key;
			logic              mode_now;
			act = ~lines;
			votes[0] = votes[0] + act[0];
			votes[1] = votes[1] + act[3];
			votes[2] = votes[2] + act[2];
			votes[3] = votes[3] + act[1];
			count = count + 1'b1;
			if (count <= limit) return;
			row = ROW_1;
			for (int i = 1; i < ROWS; i++)
				if (votes[i] > votes[row]) row = ROWI_W'(i);
			foreach (votes[i]) votes[i] = '0;
			count = '0;
			key = last_key;
			mode_now = letters;
			if (cols[COL_MID]) begin
				case (row)
					ROW_1: key = mode_now ? tap_next(key, KEY_A) : KEY_D2;
					ROW_2: key = mode_now ? tap_next(key, KEY_J) : KEY_D5;
					ROW_3: key = mode_now ? tap_next(key, KEY_T) : KEY_D8;
					default: key = !mode_now ? KEY_D0 : (key == KEY_Q) ? KEY_Z : KEY_Q;
				endcase
			end else if (cols[COL_LEFT]) begin
				case (row)
					ROW_1: key = mode_now ? KEY_SPACE : KEY_D1;
					ROW_2: key = mode_now ? tap_next(key, KEY_G) : KEY_D4;
					ROW_3: key = !mode_now ? KEY_D7 :
						(key == KEY_P) ? KEY_R : (key == KEY_R) ? KEY_S : KEY_P;
					default: begin
						letters = ~letters;
						key = KEY_STAR;
					end
				endcase
			end
			if (cols[COL_RIGHT]) begin
				case (row)
					ROW_1: key = mode_now ? tap_next(key, KEY_D) : KEY_D3;
					ROW_2: key = mode_now ? tap_next(key, KEY_M) : KEY_D6;
					ROW_3: key = mode_now ? tap_next(key, KEY_W_LET) : KEY_D9;
					default: key = KEY_CLEAR;
				endcase
			end
			last_key = key;
			if (key != KEY_STAR) pending.push_back('{key, letters});
		endfunction

		task report_mismatch(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_key(logic [KEY_W-1:0] key, logic mode);
			key_result_t want;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("key %0d mode %0b with nothing pending", key, mode));
				return;
			end
			want = pending.pop_front();
			if (key !== want.key)
				report_mismatch($sformatf("key_code %0d, predicted %0d", key, want.key));
			if (mode !== want.letter)
				report_mismatch($sformatf("letter_mode %0b, predicted %0b", mode, want.letter));
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CNT_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic [ROW_W-1:0]  row_lines;
	logic [COL_W-1:0]  column_flags;
	logic              out_valid;
	logic              out_ready;
	logic [KEY_W-1:0]  key_code;
	logic              letter_mode;

	key_tracker keys = new();
	int burst_left = 0;
	int idle_cycles = 0;
	bit hold_out = 1'b0;
	bit hold_done = 1'b0;

	keypad_vote_multitap_decoder_unit DUT (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) keys.check_key(key_code, letter_mode);
			if (cfg_valid && cfg_ready) keys.set_limit(cfg_data);
			if (in_valid && in_ready) keys.note_event(row_lines, column_flags);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
				(out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side: random stretches of full speed, coin flips, a fixed pattern
	// and heavy stalls, plus one long hold-off on request
	initial begin
		int span;
		int style;
		int tick;
		tick = 0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			style = $urandom_range(0, 3);
			span = $urandom_range(8, 80);
			repeat (span) begin
				@(posedge clk);
				tick++;
				if (hold_out && !hold_done) begin
					out_ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_done = 1'b1;
				end
				case (style)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= (tick % 5) > 1;
					default: out_ready <= ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	function automatic logic [ROW_W-1:0] row_drive(input logic [ROWI_W-1:0] row);
		case (row)
			ROW_1: return 4'b1110;
			ROW_2: return 4'b0111;
			ROW_3: return 4'b1011;
			default: return 4'b1101;
		endcase
	endfunction

	task automatic send_event(input logic [ROW_W-1:0] lines, input logic [COL_W-1:0] cols);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		row_lines <= lines;
		column_flags <= cols;
		burst_left--;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic tap(input logic [ROWI_W-1:0] row, input logic [COL_W-1:0] cols);
		send_event(row_drive(row), cols);
	endtask

	task automatic write_limit(input logic [CNT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// wait for every predicted key, then for items still inside the block
	task automatic drain_block();
		in_valid <= 1'b0;
		while (keys.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int lim, input int target);
		int sent;
		int reps;
		int n_ev;
		int pick;
		bit noisy;
		logic [ROWI_W-1:0] row;
		logic [COL_W-1:0]  cols;
		drain_block();
		write_limit(lim[CNT_W-1:0]);
		// request the long result hold-off, given only once, while items keep coming
		hold_out = 1'b1;
		sent = 0;
		while (sent < target) begin
			row = ROWI_W'($urandom_range(0, ROWS - 1));
			pick = $urandom_range(0, 19);
			if (pick < 6) cols = C_MID;
			else if (pick < 11) cols = C_LEFT;
			else if (pick < 14) cols = C_RIGHT;
			else if (pick < 17) cols = COL_W'($urandom);
			else cols = C_NONE;
			reps = $urandom_range(1, 4);
			noisy = ($urandom_range(0, 6) == 0);
			n_ev = (lim > 32) ? $urandom_range(20, 60) : lim + 1;
			repeat (reps) repeat (n_ev) begin
				if (noisy) send_event(ROW_W'($urandom), COL_W'($urandom));
				else if ($urandom_range(0, 4) == 0) send_event(row_drive(row) & ROW_W'($urandom), cols);
				else send_event(row_drive(row), cols);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		row_lines <= '1;
		column_flags <= C_NONE;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every item decides; digit mode first
		write_limit('0);
		send_event(4'b0000, C_MID);
		tap(ROW_1, C_LEFT);
		tap(ROW_1, C_RIGHT);
		tap(ROW_2, C_MID);
		tap(ROW_2, C_LEFT);
		tap(ROW_2, C_RIGHT);
		tap(ROW_3, C_MID);
		tap(ROW_3, C_LEFT);
		tap(ROW_3, C_RIGHT);
		tap(ROW_4, C_MID);
		tap(ROW_4, C_RIGHT);
		send_event(4'b1111, C_NONE);
		tap(ROW_2, C_MID | C_LEFT);
		tap(ROW_3, C_MID | C_RIGHT);
		// star, then a silent repeat of the star key
		tap(ROW_4, C_LEFT);
		tap(ROW_1, C_NONE);
		// letter mode taps with wrap-around
		repeat (4) tap(ROW_1, C_MID);
		repeat (2) tap(ROW_3, C_LEFT);
		repeat (2) tap(ROW_4, C_MID);
		tap(ROW_1, C_LEFT);
		tap(ROW_2, C_MID | C_RIGHT);
		tap(ROW_4, C_LEFT | C_RIGHT);

		run_phase(0, 250);
		run_phase(1, 300);
		run_phase(1023, 150);
		run_phase(2, 250);
		run_phase($urandom_range(3, 12), 300);
		run_phase(400, 420);
		drain_block();

		if (keys.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
